// File: hw/rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package utd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned UNIT_W    = 16;
    localparam int unsigned PARTIAL_W = 31;
    localparam int unsigned REM_W     = 3;
    localparam int unsigned CODE_W    = 20;

    localparam logic [PARTIAL_W-1:0] BMP_LIMIT   = 31'h0001_0000;
    localparam logic [PARTIAL_W-1:0] CODE_LIMIT  = 31'h0011_0000;
    localparam logic [5:0]           HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]           LO_SURR_TAG = 6'b110111;

    typedef struct packed {
        logic              pair;
        logic [CODE_W-1:0] code;
    } entry_t;

endpackage

// File: hw/rtl/utf8_to_utf16_decoder_core.sv
// Top level of the UTF-8 to UTF-16 decoder.
//
// Input stream: one UTF-8 byte per word on s_axis_tdata; s_axis_tlast marks
// the last byte of a buffer, and a sequence still incomplete after it is
// discarded. Bytes 0xFE and 0xFF as lead bytes and code points of 0x110000
// or more give no output.
// Output stream: one UTF-16 code unit per word on m_axis_tdata; m_axis_tlast
// is set on the last unit caused by an input byte. A supplementary code
// point leaves as a high then a low surrogate on consecutive words.
// A completing byte's code point is registered in a queue slot, then its first
// unit in the output word. Throughput: one byte per cycle in while the queue
// has room, one unit per cycle out while the receiver is ready; a surrogate
// pair takes two output words, which the four bytes behind it more than cover.
// The front end takes bytes while the queue of DEPTH code points has room;
// when the receiver stalls, the output word holds, the queue fills, and
// then s_axis_tready drops.
// Reset clears the pending sequence, empties the queue and clears m_axis_tvalid.
module utf8_to_utf16_decoder_core
    import utd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] byte_in
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] unit
    output logic              m_axis_tlast
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t head;
    logic   not_empty;
    logic   full;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    utd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_in    (s_axis_tdata),
        .frame_end  (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    utd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .full       (full)
    );

    utd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_unit  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: hw/rtl/utd_front.sv
// Front end: gathers UTF-8 bytes into code points and classifies them.
module utd_front
    import utd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              frame_end,
    output logic              push,
    output entry_t            push_entry
);

    logic [PARTIAL_W-1:0] partial_reg, partial_next;
    logic [REM_W-1:0]     remaining_reg, remaining_next;
    logic [PARTIAL_W-1:0] value;
    logic                 done;

    always_comb
    begin
        partial_next   = partial_reg;
        remaining_next = remaining_reg;
        value          = '0;
        done           = 1'b0;
        if (remaining_reg == '0)
        begin
            case (byte_in) inside
                [8'h00:8'h7F]:
                begin
                    value = {{(PARTIAL_W-BYTE_W){1'b0}}, byte_in};
                    done  = 1'b1;
                end
                [8'h80:8'hDF]:
                begin
                    partial_next   = {{(PARTIAL_W-5){1'b0}}, byte_in[4:0]};
                    remaining_next = REM_W'(1);
                end
                [8'hE0:8'hEF]:
                begin
                    partial_next   = {{(PARTIAL_W-4){1'b0}}, byte_in[3:0]};
                    remaining_next = REM_W'(2);
                end
                [8'hF0:8'hF7]:
                begin
                    partial_next   = {{(PARTIAL_W-3){1'b0}}, byte_in[2:0]};
                    remaining_next = REM_W'(3);
                end
                [8'hF8:8'hFB]:
                begin
                    partial_next   = {{(PARTIAL_W-2){1'b0}}, byte_in[1:0]};
                    remaining_next = REM_W'(4);
                end
                [8'hFC:8'hFD]:
                begin
                    partial_next   = {{(PARTIAL_W-1){1'b0}}, byte_in[0]};
                    remaining_next = REM_W'(5);
                end
                default:
                begin
                    partial_next   = partial_reg;
                    remaining_next = remaining_reg;
                end
            endcase
        end
        else
        begin
            value          = {partial_reg[PARTIAL_W-7:0], byte_in[5:0]};
            remaining_next = remaining_reg - REM_W'(1);
            partial_next   = value;
            if (remaining_next == '0)
            begin
                done         = 1'b1;
                partial_next = '0;
            end
        end
        if (frame_end && remaining_next != '0)
        begin
            partial_next   = '0;
            remaining_next = '0;
        end
    end

    always_comb
    begin
        push            = 1'b0;
        push_entry.pair = 1'b0;
        push_entry.code = value[CODE_W-1:0];
        if (accept && done)
        begin
            if (value < BMP_LIMIT)
            begin
                push = 1'b1;
            end
            else if (value < CODE_LIMIT)
            begin
                push            = 1'b1;
                push_entry.pair = 1'b1;
                push_entry.code = CODE_W'(value - BMP_LIMIT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// File: hw/rtl/utd_queue.sv
// Short queue of classified code points between front and back ends.
module utd_queue
    import utd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty,
    output logic   full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: hw/rtl/utd_back.sv
// Back end: turns queued code points into one or two UTF-16 words.
module utd_back
    import utd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  entry_t            head,
    input  logic              not_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [UNIT_W-1:0] out_unit,
    output logic              out_last
);

    logic              valid_reg, valid_next;
    logic              phase_reg, phase_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic              last_reg, last_next;
    logic              load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        unit_next  = unit_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (phase_reg)
            begin
                valid_next = 1'b1;
                unit_next  = {LO_SURR_TAG, head.code[9:0]};
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
            else if (not_empty)
            begin
                valid_next = 1'b1;
                if (head.pair)
                begin
                    unit_next  = {HI_SURR_TAG, head.code[19:10]};
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    unit_next = head.code[UNIT_W-1:0];
                    last_next = 1'b1;
                    pop       = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        last_reg <= last_next;
    end

`ifndef ASSERT_OFF
    a_phase_shown: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (valid_reg && !last_reg))
        else $error("pair half pending without high surrogate shown");
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && !out_ready) |=> phase_reg)
        else $error("pair half lost during stall");
    a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (load && not_empty))
        else $error("pop without output load");
`endif

endmodule
